[rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, byte constants and decode helpers of the strict UTF-8 decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam logic [20:0] REPLACEMENT  = 21'h00FFFD;
    localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
    localparam logic [7:0]  LEAD_MIN     = 8'hC2;
    localparam logic [7:0]  LEAD_LIMIT   = 8'hF5;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
    localparam logic [7:0]  LEAD_SURR    = 8'hED;
    localparam logic [7:0]  LEAD_TOP     = 8'hF4;
    localparam logic [7:0]  FOLLOW_A0    = 8'hA0;
    localparam logic [7:0]  FOLLOW_90    = 8'h90;

    typedef struct packed {
        logic [20:0] code_point;
        logic        malformed;
        logic [2:0]  bytes_used;
        logic        end_of_text;
        logic        text_valid;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    typedef struct packed {
        logic        emit;
        logic        bad;
        result_t     res;
        logic        pend;
        logic [7:0]  lead;
        logic [1:0]  remain;
        logic [20:0] partial;
    } start_t;

    typedef struct packed {
        logic   valid;
        entry_t data;
    } queue_head_t;

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] len;
        if (lead < LEAD_THREE) begin
            len = 3'd2;
        end else if (lead < LEAD_FOUR) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic start_t start_decode(input logic [7:0] b);
        start_t s;
        s = '0;
        if (b < ASCII_LIMIT) begin
            s.emit = 1'b1;
            s.res.code_point = {13'd0, b};
            s.res.bytes_used = 3'd1;
        end else if (b < LEAD_MIN || b >= LEAD_LIMIT) begin
            s.emit = 1'b1;
            s.bad = 1'b1;
            s.res.code_point = REPLACEMENT;
            s.res.malformed = 1'b1;
            s.res.bytes_used = 3'd1;
        end else begin
            s.pend = 1'b1;
            s.lead = b;
            if (b < LEAD_THREE) begin
                s.remain = 2'd1;
                s.partial = {16'd0, b[4:0]};
            end else if (b < LEAD_FOUR) begin
                s.remain = 2'd2;
                s.partial = {17'd0, b[3:0]};
            end else begin
                s.remain = 2'd3;
                s.partial = {18'd0, b[2:0]};
            end
        end
        return s;
    endfunction

endpackage

[rtl/utf8_strict_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_strict_decoder
// Strict UTF-8 decoder: one text byte in per transfer, decoded code points,
// substitutions and end-of-text results out.
// A result passes through the two-entry queue and then the output register.
// Throughput: one byte per cycle while the queue is not full; a byte with two
// results presents them one after the other, the second held in sec_reg.
// Reset clears the pending sequence, the error flag, the queue and the output.
// ----------------------------------------------------------------------------
module utf8_strict_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [20:0] code_point,
    output logic        malformed,
    output logic [2:0]  bytes_used,
    output logic        end_of_text,
    output logic        text_valid,
    output logic        last_of_run
);

    logic                 push;
    u8d_pkg::entry_t      push_data;
    logic                 q_full;
    logic                 pop;
    u8d_pkg::queue_head_t head;
    u8d_pkg::result_t     result;

    u8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    u8d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    u8d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign code_point  = result.code_point;
    assign malformed   = result.malformed;
    assign bytes_used  = result.bytes_used;
    assign end_of_text = result.end_of_text;
    assign text_valid  = result.text_valid;
    assign last_of_run = result.last_of_run;

endmodule

[rtl/u8d_front.sv]
// ----------------------------------------------------------------------------
// u8d_front
// Accepts text bytes, tracks the pending sequence and forms the results of
// each byte as one queue entry.
// ----------------------------------------------------------------------------
module u8d_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        data_byte,
    input  logic              q_full,
    output logic              push,
    output u8d_pkg::entry_t   push_data
);

    logic [7:0]  lead_reg, lead_next;
    logic [1:0]  remain_reg, remain_next;
    logic [20:0] partial_reg, partial_next;
    logic        first_reg, first_next;
    logic        error_reg, error_next;

    logic             accept;
    logic             r0_vld, r1_vld;
    u8d_pkg::result_t r0, r1;
    u8d_pkg::start_t  st;
    logic             follow_ok;
    logic [2:0]       taken;

    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;
    assign st         = u8d_pkg::start_decode(data_byte);
    assign taken      = u8d_pkg::seq_len(lead_reg) - {1'b0, remain_reg};

    always_comb
    begin
        follow_ok = (data_byte[7:6] == 2'b10);
        if (first_reg) begin
            if (lead_reg == u8d_pkg::LEAD_THREE && data_byte < u8d_pkg::FOLLOW_A0) begin
                follow_ok = 1'b0;
            end
            if (lead_reg == u8d_pkg::LEAD_SURR && data_byte >= u8d_pkg::FOLLOW_A0) begin
                follow_ok = 1'b0;
            end
            if (lead_reg == u8d_pkg::LEAD_FOUR && data_byte < u8d_pkg::FOLLOW_90) begin
                follow_ok = 1'b0;
            end
            if (lead_reg == u8d_pkg::LEAD_TOP && data_byte >= u8d_pkg::FOLLOW_90) begin
                follow_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        lead_next    = lead_reg;
        remain_next  = remain_reg;
        partial_next = partial_reg;
        first_next   = first_reg;
        error_next   = error_reg;
        r0_vld       = 1'b0;
        r1_vld       = 1'b0;
        r0           = '0;
        r1           = '0;
        if (data_byte == 8'd0) begin
            if (remain_reg != 2'd0) begin
                r0_vld = 1'b1;
                r0.code_point = u8d_pkg::REPLACEMENT;
                r0.malformed = 1'b1;
                r0.bytes_used = taken;
                r1_vld = 1'b1;
                r1.end_of_text = 1'b1;
            end else begin
                r0_vld = 1'b1;
                r0.end_of_text = 1'b1;
                r0.text_valid = !error_reg;
            end
            lead_next    = '0;
            remain_next  = '0;
            partial_next = '0;
            first_next   = 1'b0;
            error_next   = 1'b0;
        end else if (remain_reg == 2'd0) begin
            r0_vld = st.emit;
            r0     = st.res;
            if (st.bad) begin
                error_next = 1'b1;
            end
            if (st.pend) begin
                lead_next    = st.lead;
                remain_next  = st.remain;
                partial_next = st.partial;
                first_next   = 1'b1;
            end
        end else if (follow_ok) begin
            partial_next = {partial_reg[14:0], data_byte[5:0]};
            first_next   = 1'b0;
            remain_next  = remain_reg - 2'd1;
            if (remain_reg == 2'd1) begin
                r0_vld = 1'b1;
                r0.code_point = {partial_reg[14:0], data_byte[5:0]};
                r0.bytes_used = u8d_pkg::seq_len(lead_reg);
                lead_next    = '0;
                partial_next = '0;
            end
        end else begin
            error_next    = 1'b1;
            r0_vld        = 1'b1;
            r0.code_point = u8d_pkg::REPLACEMENT;
            r0.malformed  = 1'b1;
            r0.bytes_used = taken;
            r1_vld        = st.emit;
            r1            = st.res;
            lead_next     = st.lead;
            remain_next   = st.remain;
            partial_next  = st.partial;
            first_next    = st.pend;
        end
        r0.last_of_run = !r1_vld;
        r1.last_of_run = 1'b1;
    end

    assign push             = accept && r0_vld;
    assign push_data.two    = r1_vld;
    assign push_data.first  = r0;
    assign push_data.second = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lead_reg    <= '0;
            remain_reg  <= '0;
            partial_reg <= '0;
            first_reg   <= 1'b0;
            error_reg   <= 1'b0;
        end else if (accept) begin
            lead_reg    <= lead_next;
            remain_reg  <= remain_next;
            partial_reg <= partial_next;
            first_reg   <= first_next;
            error_reg   <= error_next;
        end
    end

endmodule

[rtl/u8d_queue.sv]
// ----------------------------------------------------------------------------
// u8d_queue
// Two-entry queue that decouples the byte front end from the result back end.
// ----------------------------------------------------------------------------
module u8d_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8d_pkg::entry_t       push_data,
    output logic                  full,
    input  logic                  pop,
    output u8d_pkg::queue_head_t  head
);

    u8d_pkg::entry_t mem [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/u8d_back.sv]
// ----------------------------------------------------------------------------
// u8d_back
// Takes queue entries and delivers their one or two results through an
// output register.
// ----------------------------------------------------------------------------
module u8d_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8d_pkg::queue_head_t  head,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output u8d_pkg::result_t      result
);

    logic             out_vld_reg, out_vld_next;
    u8d_pkg::result_t out_reg, out_next;
    logic             sec_vld_reg, sec_vld_next;
    u8d_pkg::result_t sec_reg, sec_next;
    logic             can_load;

    assign can_load     = !out_vld_reg || !result_stall;
    assign pop          = can_load && !sec_vld_reg && head.valid;
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        sec_vld_next = sec_vld_reg;
        sec_next     = sec_reg;
        if (can_load) begin
            if (sec_vld_reg) begin
                out_vld_next = 1'b1;
                out_next     = sec_reg;
                sec_vld_next = 1'b0;
            end else if (head.valid) begin
                out_vld_next = 1'b1;
                out_next     = head.data.first;
                sec_vld_next = head.data.two;
                sec_next     = head.data.second;
            end else begin
                out_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sec_reg <= sec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
            sec_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            sec_vld_reg <= sec_vld_next;
        end
    end

endmodule

[dv/utf8_strict_decoder_test.sv]
// ----------------------------------------------------------------------------
// utf8_strict_decoder_test
// Self-checking testbench for the strict UTF-8 decoder. A queue-fed driver
// sends text bytes. A model inside the testbench predicts each byte's decoded
// code points, substitutions and end-of-text results. A monitor compares
// every result transfer with the oldest prediction. Both sides idle at
// random in the first two of three phases; the third has no idling.
// ----------------------------------------------------------------------------
module utf8_strict_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_MARK = -1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [20:0] code_point;
    logic        malformed;
    logic [2:0]  bytes_used;
    logic        end_of_text;
    logic        text_valid;
    logic        last_of_run;

    int               byte_feed_q[$];
    u8d_pkg::result_t decoded_q[$];
    int               items_queued = 0;
    int               fail_count = 0;
    int               send_idle_pct = 17;
    int               recv_stall_pct = 70;

    logic [7:0]       seq_lead = 8'h00;
    logic [1:0]       seq_remaining = 2'd0;
    logic [20:0]      seq_partial = 21'd0;
    logic             seq_first_follow = 1'b0;
    logic             text_error = 1'b0;
    u8d_pkg::result_t byte_results [0:1];
    int               byte_result_count;

    utf8_strict_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_point   (code_point),
        .malformed    (malformed),
        .bytes_used   (bytes_used),
        .end_of_text  (end_of_text),
        .text_valid   (text_valid),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [2:0] span_of(input logic [7:0] lead);
        if (lead < u8d_pkg::LEAD_THREE)
        begin
            return 3'd2;
        end
        else if (lead < u8d_pkg::LEAD_FOUR)
        begin
            return 3'd3;
        end
        return 3'd4;
    endfunction

    function automatic logic [2:0] taken_so_far();
        return span_of(seq_lead) - {1'b0, seq_remaining};
    endfunction

    task automatic add_result(input logic [20:0] cp, input logic bad, input logic [2:0] used,
                              input logic eot, input logic tv);
        u8d_pkg::result_t r;
        r.code_point = cp;
        r.malformed = bad;
        r.bytes_used = used;
        r.end_of_text = eot;
        r.text_valid = tv;
        r.last_of_run = 1'b0;
        byte_results[byte_result_count] = r;
        byte_result_count++;
    endtask

    task automatic clear_sequence();
        seq_lead = 8'h00;
        seq_remaining = 2'd0;
        seq_partial = 21'd0;
        seq_first_follow = 1'b0;
    endtask

    task automatic start_fresh(input logic [7:0] b);
        if (b < u8d_pkg::ASCII_LIMIT)
        begin
            add_result({13'd0, b}, 1'b0, 3'd1, 1'b0, 1'b0);
        end
        else if (b < u8d_pkg::LEAD_MIN || b >= u8d_pkg::LEAD_LIMIT)
        begin
            text_error = 1'b1;
            add_result(u8d_pkg::REPLACEMENT, 1'b1, 3'd1, 1'b0, 1'b0);
        end
        else
        begin
            seq_lead = b;
            seq_first_follow = 1'b1;
            if (b < u8d_pkg::LEAD_THREE)
            begin
                seq_remaining = 2'd1;
                seq_partial = {16'd0, b[4:0]};
            end
            else if (b < u8d_pkg::LEAD_FOUR)
            begin
                seq_remaining = 2'd2;
                seq_partial = {17'd0, b[3:0]};
            end
            else
            begin
                seq_remaining = 2'd3;
                seq_partial = {18'd0, b[2:0]};
            end
        end
    endtask

    function automatic logic follow_accepted(input logic [7:0] b);
        if (b[7:6] != 2'b10)
        begin
            return 1'b0;
        end
        if (seq_first_follow)
        begin
            if (seq_lead == u8d_pkg::LEAD_THREE && b < u8d_pkg::FOLLOW_A0) return 1'b0;
            if (seq_lead == u8d_pkg::LEAD_SURR && b >= u8d_pkg::FOLLOW_A0) return 1'b0;
            if (seq_lead == u8d_pkg::LEAD_FOUR && b < u8d_pkg::FOLLOW_90) return 1'b0;
            if (seq_lead == u8d_pkg::LEAD_TOP && b >= u8d_pkg::FOLLOW_90) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        byte_result_count = 0;
        if (b == 8'h00)
        begin
            if (seq_remaining != 2'd0)
            begin
                text_error = 1'b1;
                add_result(u8d_pkg::REPLACEMENT, 1'b1, taken_so_far(), 1'b0, 1'b0);
            end
            add_result(21'd0, 1'b0, 3'd0, 1'b1, !text_error);
            clear_sequence();
            text_error = 1'b0;
        end
        else if (seq_remaining == 2'd0)
        begin
            start_fresh(b);
        end
        else if (follow_accepted(b))
        begin
            seq_partial = {seq_partial[14:0], b[5:0]};
            seq_first_follow = 1'b0;
            seq_remaining = seq_remaining - 2'd1;
            if (seq_remaining == 2'd0)
            begin
                add_result(seq_partial, 1'b0, span_of(seq_lead), 1'b0, 1'b0);
                clear_sequence();
            end
        end
        else
        begin
            text_error = 1'b1;
            add_result(u8d_pkg::REPLACEMENT, 1'b1, taken_so_far(), 1'b0, 1'b0);
            clear_sequence();
            start_fresh(b);
        end
        if (byte_result_count > 0)
        begin
            byte_results[byte_result_count - 1].last_of_run = 1'b1;
        end
        for (int k = 0; k < byte_result_count; k++)
        begin
            decoded_q.push_back(byte_results[k]);
        end
    endtask

    task automatic note_failure(input string msg);
        if (fail_count < 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    function automatic int utf8_length(input int unsigned cp);
        if (cp < 'h80) return 1;
        if (cp < 'h800) return 2;
        if (cp < 'h10000) return 3;
        return 4;
    endfunction

    function automatic logic [31:0] utf8_encode(input int unsigned cp);
        logic [20:0] v;
        v = cp[20:0];
        if (cp < 'h80)
        begin
            return {v[7:0], 24'd0};
        end
        else if (cp < 'h800)
        begin
            return {3'b110, v[10:6], 2'b10, v[5:0], 16'd0};
        end
        else if (cp < 'h10000)
        begin
            return {4'b1110, v[15:12], 2'b10, v[11:6], 2'b10, v[5:0], 8'd0};
        end
        return {5'b11110, v[20:18], 2'b10, v[17:12], 2'b10, v[11:6], 2'b10, v[5:0]};
    endfunction

    function automatic int unsigned pick_scalar(input int min_len);
        case ($urandom_range(min_len, 4))
            1: return $urandom_range(1, 'h7F);
            2: return $urandom_range('h80, 'h7FF);
            3:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    return $urandom_range('h800, 'hD7FF);
                end
                return $urandom_range('hE000, 'hFFFF);
            end
            default: return $urandom_range('h10000, 'h10FFFF);
        endcase
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        byte_feed_q.push_back(int'(b));
        items_queued++;
    endtask

    task automatic queue_prefix(input logic [31:0] enc, input int n);
        for (int k = 0; k < n; k++)
        begin
            queue_byte(enc[31 - 8 * k -: 8]);
        end
    endtask

    task automatic queue_random_text(input int target);
        int          pick;
        int unsigned cp;
        logic [7:0]  lead;
        target += items_queued;
        while (items_queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                cp = pick_scalar(1);
                queue_prefix(utf8_encode(cp), utf8_length(cp));
            end
            else if (pick < 58)
            begin
                queue_byte(8'h00);
            end
            else if (pick < 70)
            begin
                cp = pick_scalar(2);
                queue_prefix(utf8_encode(cp), $urandom_range(1, utf8_length(cp) - 1));
            end
            else if (pick < 78)
            begin
                case ($urandom_range(0, 3))
                    0: lead = u8d_pkg::LEAD_THREE;
                    1: lead = u8d_pkg::LEAD_SURR;
                    2: lead = u8d_pkg::LEAD_FOUR;
                    default: lead = u8d_pkg::LEAD_TOP;
                endcase
                queue_byte(lead);
                repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range('h80, 'hBF)));
            end
            else if (pick < 90)
            begin
                queue_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                queue_byte(8'($urandom_range('h80, 'hFF)));
            end
        end
    endtask

    task automatic wait_for_drain();
        while (byte_feed_q.size() != 0 || byte_valid || decoded_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        logic       took;
        logic       next_valid;
        logic [7:0] next_byte;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            data_byte <= 8'h00;
        end
        else
        begin
            took = byte_valid && !byte_stall;
            if (took)
            begin
                decode_byte(data_byte);
            end
            if (!byte_valid || took)
            begin
                next_valid = 1'b0;
                next_byte = data_byte;
                if (byte_feed_q.size() != 0 && byte_feed_q[0] == HOLD_MARK
                    && decoded_q.size() == 0)
                begin
                    void'(byte_feed_q.pop_front());
                end
                if (byte_feed_q.size() != 0 && byte_feed_q[0] != HOLD_MARK
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_valid = 1'b1;
                    next_byte = 8'(byte_feed_q.pop_front());
                end
                byte_valid <= next_valid;
                data_byte <= next_byte;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        u8d_pkg::result_t seen;
        u8d_pkg::result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                seen = {code_point, malformed, bytes_used, end_of_text, text_valid,
                        last_of_run};
                if (decoded_q.size() == 0)
                begin
                    note_failure($sformatf("unexpected result transfer cp=%h mal=%b used=%0d",
                                           seen.code_point, seen.malformed, seen.bytes_used));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (seen !== want)
                    begin
                        note_failure($sformatf({"result mismatch: expected cp=%h mal=%b ",
                            "used=%0d eot=%b tv=%b last=%b, got cp=%h mal=%b used=%0d ",
                            "eot=%b tv=%b last=%b"},
                            want.code_point, want.malformed, want.bytes_used,
                            want.end_of_text, want.text_valid, want.last_of_run,
                            seen.code_point, seen.malformed, seen.bytes_used,
                            seen.end_of_text, seen.text_valid, seen.last_of_run));
                    end
                end
            end
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        logic [7:0] opening [0:23];
        opening = '{8'h41, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
                    8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4, 8'h90,
                    8'hFF, 8'hC1, 8'hE2, 8'h82, 8'h41, 8'hF0, 8'h90, 8'h00};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < 24; k++)
        begin
            queue_byte(opening[k]);
        end
        byte_feed_q.push_back(HOLD_MARK);
        queue_random_text(230);
        wait_for_drain();

        send_idle_pct = 70;
        recv_stall_pct = 17;
        queue_random_text(120);
        byte_feed_q.push_back(HOLD_MARK);
        queue_random_text(110);
        wait_for_drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random_text(240);
        wait_for_drain();

        repeat (20) @(posedge clk);
        if (fail_count == 0 && decoded_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin : watchdog
        #500000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
